### rtl/core/psm_pkg.sv
// ----------------------------------------------------------------------------
// psm_pkg: shared types and constants of the seed pattern matcher
// Mode codes, register indexes, mixing constants and sequencer states.
// ----------------------------------------------------------------------------
package psm_pkg;

  localparam int unsigned ModeW  = 2;
  localparam int unsigned RegIdxW = 2;

  localparam logic [ModeW-1:0] MODE_CLEAR = 2'd0;
  localparam logic [ModeW-1:0] MODE_LOAD  = 2'd1;
  localparam logic [ModeW-1:0] MODE_TEST  = 2'd2;

  localparam logic [RegIdxW-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [RegIdxW-1:0] REG_SALT_LO   = 2'd1;
  localparam logic [RegIdxW-1:0] REG_SALT_HI   = 2'd2;
  localparam logic [RegIdxW-1:0] REG_Y_LEVEL   = 2'd3;

  localparam logic [63:0] MIX_GOLD  = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_XOR   = 64'h6a09e667f3bcc909;
  localparam logic [63:0] MIX_MUL_A = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL_B = 64'h94d049bb133111eb;

  localparam logic [63:0] HASH_MUL_X = 64'd3129871;
  localparam logic [63:0] HASH_MUL_Z = 64'd116129781;
  localparam logic [63:0] HASH_MUL_V = 64'd42317861;
  localparam logic [63:0] HASH_MUL_L = 64'd11;

  localparam logic [7:0] Y_LEVEL_RESET = 8'hc4;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MUL,
    ST_LD1,
    ST_LD2,
    ST_LD3,
    ST_LD4,
    ST_LD5,
    ST_T1,
    ST_T2,
    ST_T3,
    ST_T4,
    ST_T5,
    ST_T6,
    ST_T7,
    ST_T8,
    ST_T9,
    ST_C_RD,
    ST_C_SUM,
    ST_C_CHK,
    ST_DONE
  } state_t;

  function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned s);
    rotl64 = (v << s) | (v >> (64 - s));
  endfunction

endpackage

### rtl/core/prng_seed_pattern_matcher.sv
// ----------------------------------------------------------------------------
// prng_seed_pattern_matcher: brute-force seed checker against a cell pattern
// Stores coordinate hashes of observed cells and tests candidate seeds with
// xoroshiro128++ over one shared 32x32 multiplier under a small sequencer.
// ----------------------------------------------------------------------------
//  channel | direction | tdata / tuser
//  in_     | slave     | tdata: cell_x, cell_z, want_bedrock, seed_value; tuser: mode
//  out_    | master    | tdata: tested_seed, matched, empty_pattern
//  cfg_    | write     | cfg_index selects register, cfg_wdata carries value
//
//  a 64-bit multiply is three passes of the 32x32 multiplier
//  a test mixes the seed, then walks the stored cells in order,
//  the cell walk ending at the first mismatch
//  reset clears control, count and registers; the cell store holds no reset
//  input is taken only in idle; a result waits in the output register and the
//  next item is taken meanwhile, the following result stalls until it drains
// ----------------------------------------------------------------------------
module prng_seed_pattern_matcher
  import psm_pkg::*;
#(
  parameter int unsigned MAX_CELL_COUNT = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [135:0]        in_tdata,   // cell_x[31:0], cell_z[63:32], want_bedrock[64],
                                          // seed_value[128:65], zero pad
  input  logic [ModeW-1:0]    in_tuser,   // mode
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [71:0]         out_tdata,  // tested_seed[63:0], matched[64],
                                          // empty_pattern[65], zero pad
  input  logic                cfg_wr_en,
  input  logic [RegIdxW-1:0]  cfg_index,
  input  logic [63:0]         cfg_wdata
);

  localparam int unsigned AW = (MAX_CELL_COUNT > 1) ? $clog2(MAX_CELL_COUNT) : 1;
  localparam int unsigned CW = $clog2(MAX_CELL_COUNT + 1) > AW ?
                               $clog2(MAX_CELL_COUNT + 1) : AW;
  localparam logic [CW-1:0] CntMax = CW'(MAX_CELL_COUNT);

  // configuration
  logic [23:0] thr_r;
  logic [63:0] salt_lo_r;
  logic [63:0] salt_hi_r;
  logic [7:0]  y_r;

  // cell store
  logic [63:0] hash_mem [MAX_CELL_COUNT];
  logic        want_mem [MAX_CELL_COUNT];
  logic [63:0] rd_hash_r;
  logic        rd_want_r;
  logic        mem_we;
  logic [63:0] mem_wdata;

  state_t      state_r, state_nxt;
  state_t      ret_r, ret_nxt;
  logic [1:0]  mph_r, mph_nxt;
  logic [63:0] mop_a_r, mop_a_nxt;
  logic [63:0] mop_b_r, mop_b_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic [63:0] l_r, l_nxt;
  logic [63:0] h_r, h_nxt;
  logic [63:0] sum_r, sum_nxt;
  logic [63:0] a_r, a_nxt;
  logic [63:0] f_lo_r, f_lo_nxt;
  logic [63:0] f_hi_r, f_hi_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [31:0] z_r, z_nxt;
  logic        want_r, want_nxt;
  logic [63:0] seed_r, seed_nxt;
  logic        ok_r, ok_nxt;
  logic        ovalid_r, ovalid_nxt;
  logic [63:0] oseed_r, oseed_nxt;
  logic        omatch_r, omatch_nxt;
  logic        oempty_r, oempty_nxt;

  logic [31:0] mul_x, mul_y;
  logic [63:0] mul_p;
  logic        in_acc;
  logic [63:0] y_ext;
  logic [63:0] v_mix;
  logic [63:0] seed_mix;
  logic [63:0] gen_r;
  logic [63:0] gen_b;
  logic [63:0] hash_sum;
  logic        got;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = {6'd0, oempty_r, omatch_r, oseed_r};

  // shared multiplier: low 64 bits of a 64x64 product over three passes
  always_comb begin
    case (mph_r)
      2'd0:    begin mul_x = mop_a_r[31:0];  mul_y = mop_b_r[31:0];  end
      2'd1:    begin mul_x = mop_a_r[31:0];  mul_y = mop_b_r[63:32]; end
      default: begin mul_x = mop_a_r[63:32]; mul_y = mop_b_r[31:0];  end
    endcase
  end
  assign mul_p = mul_x * mul_y;

  assign y_ext    = {{56{y_r[7]}}, y_r};
  assign v_mix    = l_r ^ prod_r ^ y_ext;
  assign seed_mix = in_tdata[128:65] ^ MIX_XOR;
  assign gen_r    = rotl64(sum_r, 17) + l_r;
  assign gen_b    = h_r ^ l_r;
  assign hash_sum = h_r + prod_r;
  assign got      = (rotl64(sum_r, 17) + a_r) >> 40 < 64'(thr_r);

  always_comb begin
    state_nxt  = state_r;
    ret_nxt    = ret_r;
    mph_nxt    = mph_r;
    mop_a_nxt  = mop_a_r;
    mop_b_nxt  = mop_b_r;
    prod_nxt   = prod_r;
    l_nxt      = l_r;
    h_nxt      = h_r;
    sum_nxt    = sum_r;
    a_nxt      = a_r;
    f_lo_nxt   = f_lo_r;
    f_hi_nxt   = f_hi_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    z_nxt      = z_r;
    want_nxt   = want_r;
    seed_nxt   = seed_r;
    ok_nxt     = ok_r;
    ovalid_nxt = ovalid_r && !out_tready;
    oseed_nxt  = oseed_r;
    omatch_nxt = omatch_r;
    oempty_nxt = oempty_r;
    mem_we     = 1'b0;
    mem_wdata  = 64'($signed(hash_sum) >>> 16);

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_tuser)
            MODE_CLEAR: cnt_nxt = '0;
            MODE_LOAD: begin
              if (cnt_r < CntMax) begin
                z_nxt     = in_tdata[63:32];
                want_nxt  = in_tdata[64];
                mop_a_nxt = {32'd0, in_tdata[31:0]};
                mop_b_nxt = HASH_MUL_X;
                ret_nxt   = ST_LD1;
                state_nxt = ST_MUL;
              end
            end
            MODE_TEST: begin
              seed_nxt  = in_tdata[128:65];
              l_nxt     = seed_mix;
              h_nxt     = seed_mix + MIX_GOLD;
              state_nxt = ST_T1;
            end
            default: ;
          endcase
        end
      end
      ST_MUL: begin
        if (mph_r == 2'd0) begin
          prod_nxt = mul_p;
          mph_nxt  = 2'd1;
        end else begin
          prod_nxt = prod_r + {mul_p[31:0], 32'd0};
          if (mph_r == 2'd1) begin
            mph_nxt = 2'd2;
          end else begin
            mph_nxt   = 2'd0;
            state_nxt = ret_r;
          end
        end
      end
      // coordinate hash
      ST_LD1: begin
        l_nxt     = {{32{prod_r[31]}}, prod_r[31:0]};
        mop_a_nxt = {{32{z_r[31]}}, z_r};
        mop_b_nxt = HASH_MUL_Z;
        ret_nxt   = ST_LD2;
        state_nxt = ST_MUL;
      end
      ST_LD2: begin
        l_nxt     = v_mix;
        mop_a_nxt = v_mix;
        mop_b_nxt = v_mix;
        ret_nxt   = ST_LD3;
        state_nxt = ST_MUL;
      end
      ST_LD3: begin
        mop_a_nxt = prod_r;
        mop_b_nxt = HASH_MUL_V;
        ret_nxt   = ST_LD4;
        state_nxt = ST_MUL;
      end
      ST_LD4: begin
        h_nxt     = prod_r;
        mop_a_nxt = l_r;
        mop_b_nxt = HASH_MUL_L;
        ret_nxt   = ST_LD5;
        state_nxt = ST_MUL;
      end
      ST_LD5: begin
        mem_we    = 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = ST_IDLE;
      end
      // seed mixing
      ST_T1: begin
        mop_a_nxt = l_r ^ (l_r >> 30);
        mop_b_nxt = MIX_MUL_A;
        ret_nxt   = ST_T2;
        state_nxt = ST_MUL;
      end
      ST_T2: begin
        l_nxt     = prod_r;
        mop_a_nxt = h_r ^ (h_r >> 30);
        ret_nxt   = ST_T3;
        state_nxt = ST_MUL;
      end
      ST_T3: begin
        h_nxt     = prod_r;
        mop_a_nxt = l_r ^ (l_r >> 27);
        mop_b_nxt = MIX_MUL_B;
        ret_nxt   = ST_T4;
        state_nxt = ST_MUL;
      end
      ST_T4: begin
        l_nxt     = prod_r;
        mop_a_nxt = h_r ^ (h_r >> 27);
        ret_nxt   = ST_T5;
        state_nxt = ST_MUL;
      end
      ST_T5: begin
        h_nxt     = prod_r ^ (prod_r >> 31);
        l_nxt     = l_r ^ (l_r >> 31);
        state_nxt = ST_T6;
      end
      // two generator steps give the factory state
      ST_T6: begin
        sum_nxt   = l_r + h_r;
        state_nxt = ST_T7;
      end
      ST_T7: begin
        f_lo_nxt  = gen_r ^ salt_lo_r;
        l_nxt     = rotl64(l_r, 49) ^ gen_b ^ (gen_b << 21);
        h_nxt     = rotl64(gen_b, 28);
        state_nxt = ST_T8;
      end
      ST_T8: begin
        sum_nxt   = l_r + h_r;
        state_nxt = ST_T9;
      end
      ST_T9: begin
        f_hi_nxt = gen_r ^ salt_hi_r;
        idx_nxt  = '0;
        ok_nxt   = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_C_RD;
        end
      end
      // cell walk, store read data is registered and lands in the cycle after the address
      ST_C_RD: begin
        state_nxt = ST_C_SUM;
      end
      ST_C_SUM: begin
        a_nxt     = rd_hash_r ^ f_lo_r;
        sum_nxt   = (rd_hash_r ^ f_lo_r) + f_hi_r;
        state_nxt = ST_C_CHK;
      end
      ST_C_CHK: begin
        if (got != rd_want_r) begin
          ok_nxt    = 1'b0;
          state_nxt = ST_DONE;
        end else if (idx_r + 1'b1 == cnt_r) begin
          state_nxt = ST_DONE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_C_RD;
        end
      end
      ST_DONE: begin
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          oseed_nxt  = seed_r;
          omatch_nxt = ok_r;
          oempty_nxt = (cnt_r == '0);
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ret_r    <= ST_IDLE;
      mph_r    <= 2'd0;
      cnt_r    <= '0;
      idx_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ret_r    <= ret_nxt;
      mph_r    <= mph_nxt;
      cnt_r    <= cnt_nxt;
      idx_r    <= idx_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mop_a_r  <= mop_a_nxt;
    mop_b_r  <= mop_b_nxt;
    prod_r   <= prod_nxt;
    l_r      <= l_nxt;
    h_r      <= h_nxt;
    sum_r    <= sum_nxt;
    a_r      <= a_nxt;
    f_lo_r   <= f_lo_nxt;
    f_hi_r   <= f_hi_nxt;
    z_r      <= z_nxt;
    want_r   <= want_nxt;
    seed_r   <= seed_nxt;
    ok_r     <= ok_nxt;
    oseed_r  <= oseed_nxt;
    omatch_r <= omatch_nxt;
    oempty_r <= oempty_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hash_mem[cnt_r[AW-1:0]] <= mem_wdata;
      want_mem[cnt_r[AW-1:0]] <= want_r;
    end
    rd_hash_r <= hash_mem[idx_r[AW-1:0]];
    rd_want_r <= want_mem[idx_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r     <= '0;
      salt_lo_r <= '0;
      salt_hi_r <= '0;
      y_r       <= Y_LEVEL_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_THRESHOLD: thr_r     <= cfg_wdata[23:0];
        REG_SALT_LO:   salt_lo_r <= cfg_wdata;
        REG_SALT_HI:   salt_hi_r <= cfg_wdata;
        REG_Y_LEVEL:   y_r       <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntMax)
    else $error("cell count beyond capacity");

  a_mph_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_MUL) |-> (mph_r == 2'd0))
    else $error("multiplier pass counter busy outside multiply");

  a_test_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser == MODE_TEST) |=> !in_tready)
    else $error("test item did not start the sequencer");

  a_walk_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_C_RD) |-> (idx_r < cnt_r))
    else $error("cell walk index past stored cells");

  a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && state_nxt == ST_IDLE) |=> out_tvalid)
    else $error("finished test gave no result");
`endif

endmodule

### tb/psm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psm_checker: result predictor and scoreboard of the seed pattern matcher
// Watches the item, result and register ports, keeps its own cell store and
// register copy, works out the verdict of every test item and compares each
// result field by field with the oldest verdict waiting.
// ----------------------------------------------------------------------------
package psm_predict_pkg;
  import psm_pkg::*;

  // xoroshiro128++ output for one state, without advancing it
  function automatic logic [63:0] xoro_output(input logic [63:0] lo, input logic [63:0] hi);
    logic [63:0] s;
    s = lo + hi;
    return {s[46:0], s[63:47]} + lo;
  endfunction

  // next state as {hi, lo}
  function automatic logic [127:0] xoro_advance(input logic [63:0] lo, input logic [63:0] hi);
    logic [63:0] b;
    logic [63:0] nlo;
    b   = hi ^ lo;
    nlo = {lo[14:0], lo[63:15]} ^ b ^ (b << 21);
    return {b[35:0], b[63:36], nlo};
  endfunction

  function automatic logic [63:0] splitmix_finish(input logic [63:0] v);
    logic [63:0] t;
    t = (v ^ (v >> 30)) * MIX_MUL_A;
    t = (t ^ (t >> 27)) * MIX_MUL_B;
    return t ^ (t >> 31);
  endfunction

  // salted factory words {f_hi, f_lo} of a candidate seed
  function automatic logic [127:0] seed_factory_words(input logic [63:0] seed,
                                                      input logic [63:0] salt_lo,
                                                      input logic [63:0] salt_hi);
    logic [63:0]  l;
    logic [63:0]  h;
    logic [63:0]  first;
    logic [127:0] nxt;
    l     = splitmix_finish(seed ^ MIX_XOR);
    h     = splitmix_finish((seed ^ MIX_XOR) + MIX_GOLD);
    first = xoro_output(l, h);
    nxt   = xoro_advance(l, h);
    return {xoro_output(nxt[63:0], nxt[127:64]) ^ salt_hi, first ^ salt_lo};
  endfunction

  function automatic logic [63:0] cell_coord_hash(input logic [31:0] x, input logic [31:0] z,
                                                  input logic [7:0] y);
    logic [31:0] xl;
    logic [63:0] v;
    xl = x * HASH_MUL_X[31:0];
    v  = {{32{xl[31]}}, xl} ^ ({{32{z[31]}}, z} * HASH_MUL_Z) ^ {{56{y[7]}}, y};
    v  = v * v * HASH_MUL_V + v * HASH_MUL_L;
    return {{16{v[63]}}, v[63:16]};
  endfunction

  function automatic logic cell_reads_bedrock(input logic [63:0] hash, input logic [127:0] fw,
                                              input logic [23:0] thr);
    logic [63:0] r;
    r = xoro_output(hash ^ fw[63:0], fw[127:64]);
    return r[63:40] < thr;
  endfunction

endpackage

module psm_checker
  import psm_pkg::*;
  import psm_predict_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_tready,
  input  logic [135:0]       in_tdata,
  input  logic [ModeW-1:0]   in_tuser,
  input  logic               out_tvalid,
  input  logic               out_tready,
  input  logic [71:0]        out_tdata,
  input  logic               cfg_wr_en,
  input  logic [RegIdxW-1:0] cfg_index,
  input  logic [63:0]        cfg_wdata,
  output logic [31:0]        pending,
  output logic [31:0]        mismatches
);

  typedef struct packed {
    logic [63:0] seed;
    logic        matched;
    logic        empty;
  } verdict_t;

  verdict_t    verdict_q[$];
  verdict_t    exp_v;
  logic [23:0] thr;
  logic [63:0] salt_lo;
  logic [63:0] salt_hi;
  logic [7:0]  y_lvl;
  logic [63:0] hash_mem [0:STORE_DEPTH-1];
  logic        want_mem [0:STORE_DEPTH-1];
  int unsigned n_cells;
  logic [127:0] fw;
  logic        ok;
  logic [63:0] seed_in;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
    $display("%0t psm_checker: %s got %h exp %h", $time, what, got, exp_val);
    mismatches = mismatches + 1;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      thr        = '0;
      salt_lo    = '0;
      salt_hi    = '0;
      y_lvl      = Y_LEVEL_RESET;
      n_cells    = 0;
      mismatches = '0;
      verdict_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_THRESHOLD: thr     = cfg_wdata[23:0];
          REG_SALT_LO:   salt_lo = cfg_wdata;
          REG_SALT_HI:   salt_hi = cfg_wdata;
          REG_Y_LEVEL:   y_lvl   = cfg_wdata[7:0];
          default: ;
        endcase
      end

      // results first, so a result at the edge of a new item is never excused by it
      if (out_tvalid && out_tready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("unexpected result, seed", out_tdata[63:0], '0);
        end else begin
          exp_v = verdict_q.pop_front();
          if (out_tdata[63:0] !== exp_v.seed)
            report_mismatch("tested_seed", out_tdata[63:0], exp_v.seed);
          if (out_tdata[64] !== exp_v.matched)
            report_mismatch("matched", {63'd0, out_tdata[64]}, {63'd0, exp_v.matched});
          if (out_tdata[65] !== exp_v.empty)
            report_mismatch("empty_pattern", {63'd0, out_tdata[65]}, {63'd0, exp_v.empty});
        end
      end

      if (in_tvalid && in_tready) begin
        case (in_tuser)
          MODE_CLEAR: n_cells = 0;
          MODE_LOAD: begin
            if (n_cells < STORE_DEPTH) begin
              hash_mem[n_cells] = cell_coord_hash(in_tdata[31:0], in_tdata[63:32], y_lvl);
              want_mem[n_cells] = in_tdata[64];
              n_cells++;
            end
          end
          MODE_TEST: begin
            seed_in = in_tdata[128:65];
            fw      = seed_factory_words(seed_in, salt_lo, salt_hi);
            ok      = 1'b1;
            for (int unsigned i = 0; i < n_cells; i++) begin
              if (ok && (cell_reads_bedrock(hash_mem[i], fw, thr) != want_mem[i]))
                ok = 1'b0;
            end
            verdict_q.push_back('{seed: seed_in, matched: ok, empty: (n_cells == 0)});
          end
          default: ;
        endcase
      end
    end
    pending = verdict_q.size();
  end

endmodule

### tb/tb_prng_seed_pattern_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_prng_seed_pattern_matcher: stimulus and verdict for the seed matcher
// Drives clear, load and test items in random bursts, builds cell patterns
// that agree with a chosen seed under the current registers, fills the cell
// store past capacity and stalls the result side, including one long hold.
// ----------------------------------------------------------------------------
module tb_prng_seed_pattern_matcher
  import psm_pkg::*;
  import psm_predict_pkg::*;
();

  localparam int unsigned      STORE_DEPTH = 1024;
  localparam int unsigned      CYCLE_LIMIT = 2000000;
  localparam logic [ModeW-1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned      RAND_ITEMS  = 350;
  localparam int unsigned      N_PHASES    = 6;

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [135:0]       in_tdata;
  logic [ModeW-1:0]   in_tuser;
  logic               out_tvalid;
  logic               out_tready;
  logic [71:0]        out_tdata;
  logic               cfg_wr_en;
  logic [RegIdxW-1:0] cfg_index;
  logic [63:0]        cfg_wdata;
  logic [31:0]        pending_results;
  logic [31:0]        mismatch_count;

  logic [23:0] thr_cfg;
  logic [63:0] salt_lo_cfg;
  logic [63:0] salt_hi_cfg;
  logic [7:0]  y_cfg;
  int unsigned items_sent;
  int unsigned burst_left;
  int unsigned cycle_cnt;
  logic        hold_req;

  prng_seed_pattern_matcher #(.MAX_CELL_COUNT(STORE_DEPTH)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  psm_checker #(.STORE_DEPTH(STORE_DEPTH)) u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .pending    (pending_results),
    .mismatches (mismatch_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial cycle_cnt = 0;
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_prng_seed_pattern_matcher: errors");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [31:0] rand_coord();
    if ($urandom_range(0, 3) == 0)
      return 32'(int'($urandom_range(0, 64)) - 32);
    return $urandom;
  endfunction

  // called just after a falling edge, returns just after one
  task automatic push_item(input logic [ModeW-1:0] mode, input logic [31:0] x,
                           input logic [31:0] z, input logic want, input logic [63:0] seed);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      burst_left = $urandom_range(1, 40);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {7'd0, seed, want, z, x};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    if (mode != MODE_UNUSED)
      items_sent++;
  endtask

  task automatic load_cell(input logic [31:0] x, input logic [31:0] z, input logic want);
    push_item(MODE_LOAD, x, z, want, rand64());
  endtask

  task automatic test_seed(input logic [63:0] seed);
    push_item(MODE_TEST, $urandom, $urandom, 1'($urandom), seed);
  endtask

  task automatic clear_cells();
    push_item(MODE_CLEAR, $urandom, $urandom, 1'($urandom), rand64());
  endtask

  // loads that agree with seed under the current registers, one bit flipped at flip_at
  task automatic load_pattern(input logic [63:0] seed, input int unsigned n,
                              input int unsigned flip_at);
    logic [127:0] fw;
    logic [31:0]  x;
    logic [31:0]  z;
    logic         w;
    fw = seed_factory_words(seed, salt_lo_cfg, salt_hi_cfg);
    for (int unsigned i = 0; i < n; i++) begin
      x = rand_coord();
      z = rand_coord();
      w = cell_reads_bedrock(cell_coord_hash(x, z, y_cfg), fw, thr_cfg);
      load_cell(x, z, (i == flip_at) ? !w : w);
    end
  endtask

  // loads without results may still be in flight once the last result is back
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic set_config(input logic [23:0] thr, input logic [63:0] slo,
                            input logic [63:0] shi, input logic [7:0] y);
    logic [63:0] junk;
    junk = rand64();
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_THRESHOLD;
    cfg_wdata <= {junk[63:24], thr};
    @(negedge clk);
    cfg_index <= REG_SALT_LO;
    cfg_wdata <= slo;
    @(negedge clk);
    cfg_index <= REG_SALT_HI;
    cfg_wdata <= shi;
    @(negedge clk);
    cfg_index <= REG_Y_LEVEL;
    cfg_wdata <= {junk[55:0], y};
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    thr_cfg     = thr;
    salt_lo_cfg = slo;
    salt_hi_cfg = shi;
    y_cfg       = y;
  endtask

  // result side: segments of full rate, random stalls and periodic stalls
  initial begin : receiver
    int unsigned seg;
    int unsigned len;
    int unsigned period;
    logic        held;
    out_tready = 1'b0;
    held       = 1'b0;
    forever begin
      if (hold_req && !held) begin
        out_tready <= 1'b0;
        repeat (1500) @(negedge clk);
        held = 1'b1;
      end
      seg    = $urandom_range(0, 2);
      len    = $urandom_range(10, 200);
      period = $urandom_range(2, 6);
      for (int unsigned k = 0; k < len; k++) begin
        case (seg)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom);
          default: out_tready <= (k % period) != 0;
        endcase
        @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [63:0] key;
    int unsigned n;
    int unsigned pick;
    int unsigned target;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = MODE_CLEAR;
    cfg_wr_en   = 1'b0;
    cfg_index   = REG_THRESHOLD;
    cfg_wdata   = '0;
    hold_req    = 1'b0;
    items_sent  = 0;
    burst_left  = 0;
    thr_cfg     = '0;
    salt_lo_cfg = '0;
    salt_hi_cfg = '0;
    y_cfg       = Y_LEVEL_RESET;
    rst_n       = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // registers at reset: threshold zero, so no cell reads as bedrock
    test_seed('0);
    test_seed(64'h7fff_ffff_ffff_ffff);
    test_seed(64'h8000_0000_0000_0000);
    push_item(MODE_UNUSED, $urandom, $urandom, 1'b1, rand64());
    load_cell(32'h8000_0000, 32'h7fff_ffff, 1'b0);
    load_cell(32'h7fff_ffff, 32'h8000_0000, 1'b0);
    load_cell('0, '0, 1'b0);
    load_cell('1, '1, 1'b0);
    test_seed('1);
    test_seed(rand64());
    load_cell($urandom, $urandom, 1'b1);
    test_seed(rand64());
    clear_cells();
    test_seed(rand64());

    wait_idle();
    set_config(24'hff_ffff, '1, '1, 8'h7f);
    clear_cells();
    load_cell(32'h8000_0000, 32'h8000_0000, 1'b1);
    load_cell(32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
    load_cell($urandom, $urandom, 1'b1);
    test_seed(rand64());
    test_seed(rand64());
    load_cell($urandom, $urandom, 1'b0);
    test_seed(rand64());

    // store full: the two loads past capacity would disagree if kept
    wait_idle();
    set_config('0, rand64(), rand64(), 8'hc0);
    clear_cells();
    for (int unsigned i = 0; i < STORE_DEPTH; i++)
      load_cell(rand_coord(), rand_coord(), 1'b0);
    load_cell($urandom, $urandom, 1'b1);
    load_cell($urandom, $urandom, 1'b1);
    test_seed(rand64());
    test_seed(rand64());
    wait_idle();
    set_config(24'h80_0000, rand64(), rand64(), 8'h40);
    test_seed(rand64());
    clear_cells();

    for (int unsigned ph = 0; ph < N_PHASES; ph++) begin
      wait_idle();
      case (ph)
        1: set_config('0, '0, '0, 8'hc0);
        2: set_config(24'hff_ffff, '1, '1, 8'h7f);
        default: set_config(24'($urandom), rand64(), rand64(),
                            8'(int'($urandom_range(0, 191)) - 64));
      endcase
      if (ph == 0)
        hold_req = 1'b1;
      target = items_sent + RAND_ITEMS / N_PHASES;
      while (items_sent < target) begin
        pick = $urandom_range(0, 9);
        key  = rand64();
        n    = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        if (pick < 7) begin
          clear_cells();
          load_pattern(key, n, n);
          test_seed(key);
          repeat ($urandom_range(1, 4)) test_seed(rand64());
          if ($urandom_range(0, 1) == 1)
            test_seed(key ^ (64'd1 << $urandom_range(0, 63)));
        end else if (pick == 7) begin
          clear_cells();
          load_pattern(key, n, $urandom_range(0, n - 1));
          test_seed(key);
        end else if (pick == 8) begin
          repeat ($urandom_range(1, 6))
            push_item(ModeW'($urandom), $urandom, $urandom, 1'($urandom), rand64());
        end else begin
          repeat ($urandom_range(1, 5)) test_seed(rand64());
        end
      end
    end

    in_tvalid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (mismatch_count == 0)
      $display("tb_prng_seed_pattern_matcher: clean");
    else
      $display("tb_prng_seed_pattern_matcher: errors");
    $finish;
  end

endmodule
